### src/jtt_pkg.sv
package jtt_pkg;

  localparam int unsigned FieldWidth = 32;
  localparam int unsigned QueueDepth = 4;

  localparam logic [3:0] KIND_END      = 4'd0;
  localparam logic [3:0] KIND_ERROR    = 4'd1;
  localparam logic [3:0] KIND_NULL     = 4'd2;
  localparam logic [3:0] KIND_BOOLEAN  = 4'd3;
  localparam logic [3:0] KIND_INTEGER  = 4'd4;
  localparam logic [3:0] KIND_STRING   = 4'd5;
  localparam logic [3:0] KIND_LPAREN   = 4'd6;
  localparam logic [3:0] KIND_RPAREN   = 4'd7;
  localparam logic [3:0] KIND_LBRACKET = 4'd8;
  localparam logic [3:0] KIND_RBRACKET = 4'd9;
  localparam logic [3:0] KIND_LBRACE   = 4'd10;
  localparam logic [3:0] KIND_RBRACE   = 4'd11;
  localparam logic [3:0] KIND_COMMA    = 4'd12;
  localparam logic [3:0] KIND_COLON    = 4'd13;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_BAD_BYTE = 3'd1;
  localparam logic [2:0] ERR_KEYWORD  = 3'd2;
  localparam logic [2:0] ERR_RANGE    = 3'd3;
  localparam logic [2:0] ERR_UNCLOSED = 3'd4;
  localparam logic [2:0] ERR_ESCAPE   = 3'd5;

  localparam logic [1:0] KW_NULL  = 2'd0;
  localparam logic [1:0] KW_TRUE  = 2'd1;
  localparam logic [1:0] KW_FALSE = 2'd2;

  typedef struct packed {
    logic [3:0]            kind;
    logic [2:0]            err;
    logic                  bval;
    logic [62:0]           ival;
    logic [FieldWidth-1:0] sstart;
    logic [FieldWidth-1:0] slen;
    logic [FieldWidth-1:0] line;
    logic [FieldWidth-1:0] col;
    logic                  last_result;
  } jtt_result_t;

  typedef struct packed {
    logic [1:0]  count;
    jtt_result_t first;
    jtt_result_t second;
  } jtt_pair_t;

  function automatic jtt_result_t mk_result(logic [3:0] kind, logic [2:0] err, logic bval,
                                            logic [62:0] ival,
                                            logic [FieldWidth-1:0] sstart,
                                            logic [FieldWidth-1:0] slen,
                                            logic [FieldWidth-1:0] line,
                                            logic [FieldWidth-1:0] col);
    jtt_result_t r;
    r.kind        = kind;
    r.err         = err;
    r.bval        = bval;
    r.ival        = ival;
    r.sstart      = sstart;
    r.slen        = slen;
    r.line        = line;
    r.col         = col;
    r.last_result = 1'b0;
    return r;
  endfunction

  function automatic logic [2:0] kw_len(logic [1:0] sel);
    return (sel == KW_FALSE) ? 3'd4 : 3'd3;
  endfunction

  // remaining characters of null, true, false after the first one
  function automatic logic [7:0] kw_char(logic [1:0] sel, logic [2:0] prog);
    logic [7:0] c;
    c = 8'h00;
    case ({sel, prog})
      {KW_NULL, 3'd0}:  c = "u";
      {KW_NULL, 3'd1}:  c = "l";
      {KW_NULL, 3'd2}:  c = "l";
      {KW_TRUE, 3'd0}:  c = "r";
      {KW_TRUE, 3'd1}:  c = "u";
      {KW_TRUE, 3'd2}:  c = "e";
      {KW_FALSE, 3'd0}: c = "a";
      {KW_FALSE, 3'd1}: c = "l";
      {KW_FALSE, 3'd2}: c = "s";
      {KW_FALSE, 3'd3}: c = "e";
      default:          c = 8'h00;
    endcase
    return c;
  endfunction

  // KIND_END when the byte is no punctuation
  function automatic logic [3:0] punct_kind(logic [7:0] b);
    logic [3:0] k;
    k = KIND_END;
    case (b)
      "(":     k = KIND_LPAREN;
      ")":     k = KIND_RPAREN;
      "[":     k = KIND_LBRACKET;
      "]":     k = KIND_RBRACKET;
      "{":     k = KIND_LBRACE;
      "}":     k = KIND_RBRACE;
      ",":     k = KIND_COMMA;
      ":":     k = KIND_COLON;
      default: k = KIND_END;
    endcase
    return k;
  endfunction

endpackage

### src/json_text_tokenizer_unit.sv
// A result enters the result queue in the cycle after the transfer of the byte that causes it.
// Throughput: one byte per cycle while the input is not stalled; a byte causing two results queues both at once.
// Results wait in a four-entry queue; input stalls when fewer than two entries are free.
// Reset (rst_ni low, asynchronous): idle, line 1, column 0, position 0, queue empty.
module json_text_tokenizer_unit #(
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       in_byte_i,
  input  logic                             end_of_input_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [3:0]                       token_kind_o,
  output logic [2:0]                       error_code_o,
  output logic                             bool_value_o,
  output logic [62:0]                      int_value_o,
  output logic [jtt_pkg::FieldWidth-1:0]   string_start_o,
  output logic [jtt_pkg::FieldWidth-1:0]   string_length_o,
  output logic [jtt_pkg::FieldWidth-1:0]   token_line_o,
  output logic [jtt_pkg::FieldWidth-1:0]   token_col_o,
  output logic                             last_result_o
);
  import jtt_pkg::*;

  logic        accept;
  logic        pop;
  logic        full;
  jtt_pair_t   pair;
  jtt_result_t head;

  assign accept = in_valid_i && !full;
  assign pop    = out_valid_o && !out_stall_i;

  jtt_scan #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .in_byte_i      (in_byte_i),
    .end_of_input_i (end_of_input_i),
    .results_o      (pair)
  );

  jtt_result_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (pair),
    .pop_i       (pop),
    .head_o      (head),
    .not_empty_o (out_valid_o),
    .full_o      (full)
  );

  assign in_stall_o      = full;
  assign token_kind_o    = head.kind;
  assign error_code_o    = head.err;
  assign bool_value_o    = head.bval;
  assign int_value_o     = head.ival;
  assign string_start_o  = head.sstart;
  assign string_length_o = head.slen;
  assign token_line_o    = head.line;
  assign token_col_o     = head.col;
  assign last_result_o   = head.last_result;

endmodule

### src/jtt_scan.sv
module jtt_scan #(
  parameter int unsigned POSITION_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       in_byte_i,
  input  logic             end_of_input_i,
  output jtt_pkg::jtt_pair_t results_o
);
  import jtt_pkg::*;

  localparam int unsigned PW = POSITION_WIDTH;
  localparam logic [PW-1:0] PosOne = PW'(1);

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_KEYWORD = 3'd1;
  localparam logic [2:0] MODE_NUMBER  = 3'd2;
  localparam logic [2:0] MODE_STRING  = 3'd3;
  localparam logic [2:0] MODE_SKIP    = 3'd4;
  localparam logic [2:0] MODE_ESCAPED = 3'd5;

  logic [2:0]    mode_q, mode_d;
  logic [1:0]    kw_sel_q, kw_sel_d;
  logic [2:0]    kw_prog_q, kw_prog_d;
  logic [62:0]   acc_q, acc_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [PW-1:0] line_q, line_d;
  logic [PW-1:0] col_q, col_d;
  logic [PW-1:0] sline_q, sline_d;
  logic [PW-1:0] scol_q, scol_d;
  logic [PW-1:0] spos_q, spos_d;
  logic          err_q, err_d;

  logic [7:0]  b;
  logic        is_digit;
  logic [3:0]  pkind;
  logic [66:0] prod;
  logic        ovf;
  logic [FieldWidth-1:0] sline32, scol32, line32, col32;

  jtt_result_t res [2];
  logic [1:0]  cnt;
  logic        slot;
  logic        idle_run;

  assign b        = in_byte_i;
  assign is_digit = (b >= "0") && (b <= "9");
  assign pkind    = punct_kind(b);
  assign prod     = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + 67'(b[3:0]);
  assign ovf      = |prod[66:63];
  assign sline32  = FieldWidth'(sline_q);
  assign scol32   = FieldWidth'(scol_q);
  assign line32   = FieldWidth'(line_q);
  assign col32    = FieldWidth'(col_q);

  always_comb begin
    mode_d    = mode_q;
    kw_sel_d  = kw_sel_q;
    kw_prog_d = kw_prog_q;
    acc_d     = acc_q;
    pos_d     = pos_q;
    line_d    = line_q;
    col_d     = col_q;
    sline_d   = sline_q;
    scol_d    = scol_q;
    spos_d    = spos_q;
    err_d     = err_q;
    res[0]    = '0;
    res[1]    = '0;
    cnt       = 2'd0;
    slot      = 1'b0;
    idle_run  = 1'b0;

    if (accept_i) begin
      if (end_of_input_i) begin
        if (!err_q) begin
          case (mode_q)
            MODE_IDLE: ;
            MODE_KEYWORD: begin
              res[0] = mk_result(KIND_ERROR, ERR_KEYWORD, 1'b0, '0, '0, '0, sline32, scol32);
              cnt    = 2'd1;
            end
            MODE_NUMBER: begin
              res[0] = mk_result(KIND_INTEGER, ERR_NONE, 1'b0, acc_q, '0, '0, sline32, scol32);
              cnt    = 2'd1;
            end
            default: begin
              res[0] = mk_result(KIND_ERROR, ERR_UNCLOSED, 1'b0, '0, '0, '0, sline32, scol32);
              cnt    = 2'd1;
            end
          endcase
        end
        res[cnt[0]] = mk_result(KIND_END, ERR_NONE, 1'b0, '0, '0, '0, line32, col32);
        cnt       = cnt + 2'd1;
        mode_d    = MODE_IDLE;
        kw_sel_d  = KW_NULL;
        kw_prog_d = 3'd0;
        acc_d     = '0;
        pos_d     = '0;
        line_d    = PosOne;
        col_d     = '0;
        sline_d   = PosOne;
        scol_d    = '0;
        spos_d    = '0;
        err_d     = 1'b0;
      end else if (!err_q) begin
        case (mode_q)
          MODE_KEYWORD: begin
            if (b == kw_char(kw_sel_q, kw_prog_q)) begin
              pos_d     = pos_q + PosOne;
              col_d     = col_q + PosOne;
              kw_prog_d = kw_prog_q + 3'd1;
              if (kw_prog_d == kw_len(kw_sel_q)) begin
                if (kw_sel_q == KW_NULL) begin
                  res[0] = mk_result(KIND_NULL, ERR_NONE, 1'b0, '0, '0, '0, sline32, scol32);
                end else begin
                  res[0] = mk_result(KIND_BOOLEAN, ERR_NONE, kw_sel_q == KW_TRUE, '0, '0, '0,
                                     sline32, scol32);
                end
                cnt    = 2'd1;
                mode_d = MODE_IDLE;
              end
            end else begin
              res[0] = mk_result(KIND_ERROR, ERR_KEYWORD, 1'b0, '0, '0, '0, sline32, scol32);
              cnt    = 2'd1;
              err_d  = 1'b1;
              mode_d = MODE_IDLE;
            end
          end
          MODE_NUMBER: begin
            if (is_digit) begin
              if (ovf) begin
                res[0] = mk_result(KIND_ERROR, ERR_RANGE, 1'b0, '0, '0, '0, sline32, scol32);
                cnt    = 2'd1;
                err_d  = 1'b1;
                mode_d = MODE_IDLE;
              end else begin
                acc_d = prod[62:0];
                pos_d = pos_q + PosOne;
                col_d = col_q + PosOne;
              end
            end else begin
              res[0]   = mk_result(KIND_INTEGER, ERR_NONE, 1'b0, acc_q, '0, '0, sline32, scol32);
              cnt      = 2'd1;
              slot     = 1'b1;
              mode_d   = MODE_IDLE;
              idle_run = 1'b1;
            end
          end
          MODE_STRING: begin
            if (b == "\"") begin
              res[0] = mk_result(KIND_STRING, ERR_NONE, 1'b0, '0, FieldWidth'(spos_q),
                                 FieldWidth'(pos_q - spos_q), sline32, scol32);
              cnt    = 2'd1;
              mode_d = MODE_IDLE;
            end else if (b == "\\") begin
              mode_d = MODE_SKIP;
            end
            pos_d = pos_q + PosOne;
            col_d = col_q + PosOne;
          end
          MODE_SKIP: begin
            mode_d = MODE_ESCAPED;
            pos_d  = pos_q + PosOne;
            col_d  = col_q + PosOne;
          end
          MODE_ESCAPED: begin
            if (b == "\"") begin
              res[0] = mk_result(KIND_ERROR, ERR_ESCAPE, 1'b0, '0, '0, '0, sline32, scol32);
              cnt    = 2'd1;
              err_d  = 1'b1;
              mode_d = MODE_IDLE;
            end else begin
              if (b == "\\") begin
                mode_d = MODE_SKIP;
              end
              pos_d = pos_q + PosOne;
              col_d = col_q + PosOne;
            end
          end
          default: begin
            mode_d   = MODE_IDLE;
            idle_run = 1'b1;
          end
        endcase

        if (idle_run) begin
          if ((b == " ") || (b == 8'h09) || (b == 8'h0B)) begin
            pos_d = pos_q + PosOne;
            col_d = col_q + PosOne;
          end else if (b == 8'h0A) begin
            pos_d  = pos_q + PosOne;
            line_d = line_q + PosOne;
            col_d  = '0;
          end else if (pkind != KIND_END) begin
            res[slot] = mk_result(pkind, ERR_NONE, 1'b0, '0, '0, '0, line32, col32);
            cnt       = cnt + 2'd1;
            pos_d     = pos_q + PosOne;
            col_d     = col_q + PosOne;
          end else if ((b == "n") || (b == "t") || (b == "f")) begin
            sline_d   = line_q;
            scol_d    = col_q;
            kw_sel_d  = (b == "n") ? KW_NULL : (b == "t") ? KW_TRUE : KW_FALSE;
            kw_prog_d = 3'd0;
            mode_d    = MODE_KEYWORD;
            pos_d     = pos_q + PosOne;
            col_d     = col_q + PosOne;
          end else if (is_digit) begin
            sline_d = line_q;
            scol_d  = col_q;
            acc_d   = 63'(b[3:0]);
            mode_d  = MODE_NUMBER;
            pos_d   = pos_q + PosOne;
            col_d   = col_q + PosOne;
          end else if (b == "\"") begin
            sline_d = line_q;
            scol_d  = col_q;
            pos_d   = pos_q + PosOne;
            col_d   = col_q + PosOne;
            spos_d  = pos_q + PosOne;
            mode_d  = MODE_STRING;
          end else begin
            res[slot] = mk_result(KIND_ERROR, ERR_BAD_BYTE, 1'b0, '0, '0, '0, line32, col32);
            cnt       = cnt + 2'd1;
            err_d     = 1'b1;
            mode_d    = MODE_IDLE;
          end
        end
      end
    end

    if (cnt == 2'd2) begin
      res[1].last_result = 1'b1;
    end else begin
      res[0].last_result = 1'b1;
    end
  end

  assign results_o.count  = cnt;
  assign results_o.first  = res[0];
  assign results_o.second = res[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_IDLE;
      kw_sel_q  <= KW_NULL;
      kw_prog_q <= 3'd0;
      acc_q     <= '0;
      pos_q     <= '0;
      line_q    <= PosOne;
      col_q     <= '0;
      sline_q   <= PosOne;
      scol_q    <= '0;
      spos_q    <= '0;
      err_q     <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      kw_sel_q  <= kw_sel_d;
      kw_prog_q <= kw_prog_d;
      acc_q     <= acc_d;
      pos_q     <= pos_d;
      line_q    <= line_d;
      col_q     <= col_d;
      sline_q   <= sline_d;
      scol_q    <= scol_d;
      spos_q    <= spos_d;
      err_q     <= err_d;
    end
  end

endmodule

### src/jtt_result_queue.sv
module jtt_result_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  jtt_pkg::jtt_pair_t   push_i,
  input  logic                 pop_i,
  output jtt_pkg::jtt_result_t head_o,
  output logic                 not_empty_o,
  output logic                 full_o
);
  import jtt_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);
  localparam logic [CntW-1:0] RoomLimit = CntW'(QueueDepth - 2);

  jtt_result_t   mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign head_o      = mem_q[rd_ptr_q];
  assign not_empty_o = cnt_q != '0;
  // room must remain for two results
  assign full_o      = cnt_q > RoomLimit;

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + PtrW'(1)] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_i.count);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop_i);
      cnt_q    <= cnt_q + CntW'(push_i.count) - CntW'(pop_i);
    end
  end

endmodule

### src/jtt_checker.sv
module jtt_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic [7:0]                     in_byte_i,
  input logic                           end_of_input_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [3:0]                     token_kind_o,
  input logic [2:0]                     error_code_o,
  input logic                           bool_value_o,
  input logic [62:0]                    int_value_o,
  input logic [jtt_pkg::FieldWidth-1:0] string_start_o,
  input logic [jtt_pkg::FieldWidth-1:0] string_length_o,
  input logic [jtt_pkg::FieldWidth-1:0] token_line_o,
  input logic [jtt_pkg::FieldWidth-1:0] token_col_o,
  input logic                           last_result_o
);
  import jtt_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(token_kind_o)
      && $stable(token_line_o) && $stable(last_result_o))
    else $error("stalled transfer changed");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o == KIND_END |-> last_result_o)
    else $error("end token not last of its step");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((token_kind_o == KIND_ERROR) == (error_code_o != ERR_NONE)))
    else $error("error code does not match token kind");

  a_bool_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o != KIND_BOOLEAN |-> !bool_value_o)
    else $error("bool value set on non-boolean token");

  a_int_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && token_kind_o != KIND_INTEGER |-> int_value_o == '0)
    else $error("int value set on non-integer token");

endmodule

bind json_text_tokenizer_unit jtt_checker u_jtt_checker (.*);

### sim/json_token_check.sv
module json_token_check (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic [7:0]                     in_byte_i,
  input  logic                           end_of_input_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [3:0]                     token_kind_i,
  input  logic [2:0]                     error_code_i,
  input  logic                           bool_value_i,
  input  logic [62:0]                    int_value_i,
  input  logic [jtt_pkg::FieldWidth-1:0] string_start_i,
  input  logic [jtt_pkg::FieldWidth-1:0] string_length_i,
  input  logic [jtt_pkg::FieldWidth-1:0] token_line_i,
  input  logic [jtt_pkg::FieldWidth-1:0] token_col_i,
  input  logic                           last_result_i,
  output int unsigned                    fail_count_o,
  output int unsigned                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import jtt_pkg::*;

  typedef enum logic [2:0] {
    SCAN_IDLE,
    SCAN_KEYWORD,
    SCAN_NUMBER,
    SCAN_STRING,
    SCAN_SKIP,
    SCAN_ESCAPED
  } scan_mode_e;

  localparam logic [63:0] INT_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [7:0]  QUOTE     = 8'h22;
  localparam logic [7:0]  BACKSLASH = 8'h5C;
  localparam string       PUNCT     = "()[]{},:";

  string kw_rest [3] = '{"ull", "rue", "alse"};

  scan_mode_e            mode;
  logic [1:0]            kw_sel;
  logic [2:0]            kw_prog;
  logic [63:0]           acc;
  logic [FieldWidth-1:0] pos, line, col;
  logic [FieldWidth-1:0] tok_line, tok_col, str_pos;
  bit                    err_seen;

  jtt_result_t step_tokens[$];
  jtt_result_t expected_tokens[$];

  function automatic void clear_state();
    mode     = SCAN_IDLE;
    kw_sel   = KW_NULL;
    kw_prog  = '0;
    acc      = '0;
    pos      = '0;
    line     = 1;
    col      = '0;
    tok_line = 1;
    tok_col  = '0;
    str_pos  = '0;
    err_seen = 1'b0;
  endfunction

  function automatic void push_token(logic [3:0] kind, logic [2:0] err, logic bval,
                                     logic [62:0] ival, logic [FieldWidth-1:0] sstart,
                                     logic [FieldWidth-1:0] slen,
                                     logic [FieldWidth-1:0] tline,
                                     logic [FieldWidth-1:0] tcol);
    jtt_result_t r;
    r.kind        = kind;
    r.err         = err;
    r.bval        = bval;
    r.ival        = ival;
    r.sstart      = sstart;
    r.slen        = slen;
    r.line        = tline;
    r.col         = tcol;
    r.last_result = 1'b0;
    step_tokens.push_back(r);
  endfunction

  function automatic void step_forward();
    pos++;
    col++;
  endfunction

  function automatic void raise_error(logic [2:0] code, logic [FieldWidth-1:0] tline,
                                      logic [FieldWidth-1:0] tcol);
    push_token(KIND_ERROR, code, 1'b0, '0, '0, '0, tline, tcol);
    err_seen = 1'b1;
    mode     = SCAN_IDLE;
  endfunction

  function automatic void note_start();
    tok_line = line;
    tok_col  = col;
  endfunction

  // byte seen where a token may begin
  function automatic void scan_fresh(logic [7:0] b);
    int slot;
    slot = -1;
    for (int i = 0; i < 8; i++)
      if (b == PUNCT[i]) slot = i;
    mode = SCAN_IDLE;
    if (b == 8'h20 || b == 8'h09 || b == 8'h0B) begin
      step_forward();
    end else if (b == 8'h0A) begin
      pos++;
      line++;
      col = '0;
    end else if (slot >= 0) begin
      push_token(4'(KIND_LPAREN + slot), ERR_NONE, 1'b0, '0, '0, '0, line, col);
      step_forward();
    end else if (b == "n" || b == "t" || b == "f") begin
      note_start();
      kw_sel  = (b == "n") ? KW_NULL : (b == "t") ? KW_TRUE : KW_FALSE;
      kw_prog = '0;
      mode    = SCAN_KEYWORD;
      step_forward();
    end else if (b >= "0" && b <= "9") begin
      note_start();
      acc  = 64'(b - 8'h30);
      mode = SCAN_NUMBER;
      step_forward();
    end else if (b == QUOTE) begin
      note_start();
      step_forward();
      str_pos = pos;
      mode    = SCAN_STRING;
    end else begin
      raise_error(ERR_BAD_BYTE, line, col);
    end
  endfunction

  function automatic void scan_next(logic [7:0] b);
    logic [63:0] d;
    d = '0;
    case (mode)
      SCAN_KEYWORD: begin
        if (b == kw_rest[kw_sel][kw_prog]) begin
          step_forward();
          kw_prog++;
          if (kw_prog == kw_rest[kw_sel].len()) begin
            if (kw_sel == KW_NULL)
              push_token(KIND_NULL, ERR_NONE, 1'b0, '0, '0, '0, tok_line, tok_col);
            else
              push_token(KIND_BOOLEAN, ERR_NONE, kw_sel == KW_TRUE, '0, '0, '0,
                         tok_line, tok_col);
            mode = SCAN_IDLE;
          end
        end else begin
          raise_error(ERR_KEYWORD, tok_line, tok_col);
        end
      end
      SCAN_NUMBER: begin
        if (b >= "0" && b <= "9") begin
          d = 64'(b - 8'h30);
          if (acc > (INT_LIMIT - d) / 64'd10) begin
            raise_error(ERR_RANGE, tok_line, tok_col);
          end else begin
            acc = acc * 64'd10 + d;
            step_forward();
          end
        end else begin
          push_token(KIND_INTEGER, ERR_NONE, 1'b0, acc[62:0], '0, '0, tok_line, tok_col);
          scan_fresh(b);
        end
      end
      SCAN_STRING: begin
        if (b == QUOTE) begin
          push_token(KIND_STRING, ERR_NONE, 1'b0, '0, str_pos, pos - str_pos,
                     tok_line, tok_col);
          step_forward();
          mode = SCAN_IDLE;
        end else begin
          if (b == BACKSLASH) mode = SCAN_SKIP;
          step_forward();
        end
      end
      SCAN_SKIP: begin
        mode = SCAN_ESCAPED;
        step_forward();
      end
      SCAN_ESCAPED: begin
        if (b == QUOTE) begin
          raise_error(ERR_ESCAPE, tok_line, tok_col);
        end else begin
          if (b == BACKSLASH) mode = SCAN_SKIP;
          step_forward();
        end
      end
      default: scan_fresh(b);
    endcase
  endfunction

  function automatic void predict_tokens(logic [7:0] b, logic eoi);
    jtt_result_t r;
    step_tokens.delete();
    if (eoi) begin
      if (!err_seen) begin
        case (mode)
          SCAN_IDLE: begin
          end
          SCAN_KEYWORD:
            push_token(KIND_ERROR, ERR_KEYWORD, 1'b0, '0, '0, '0, tok_line, tok_col);
          SCAN_NUMBER:
            push_token(KIND_INTEGER, ERR_NONE, 1'b0, acc[62:0], '0, '0, tok_line, tok_col);
          default:
            push_token(KIND_ERROR, ERR_UNCLOSED, 1'b0, '0, '0, '0, tok_line, tok_col);
        endcase
      end
      push_token(KIND_END, ERR_NONE, 1'b0, '0, '0, '0, line, col);
      clear_state();
    end else if (!err_seen) begin
      scan_next(b);
    end
    foreach (step_tokens[i]) begin
      r             = step_tokens[i];
      r.last_result = (i == step_tokens.size() - 1);
      expected_tokens.push_back(r);
    end
  endfunction

  function automatic string token_text(jtt_result_t t);
    return $sformatf("kind=%0d err=%0d bool=%0b int=%0d start=%0d len=%0d line=%0d col=%0d last=%0b",
                     t.kind, t.err, t.bval, t.ival, t.sstart, t.slen, t.line, t.col,
                     t.last_result);
  endfunction

  task automatic log_failure(string what, string detail);
    if (fail_count_o < 10) $display("%0t %s: %s", $time, what, detail);
    fail_count_o++;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    clear_state();
  end

  always @(posedge clk_i) begin
    jtt_result_t seen, want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        seen.kind        = token_kind_i;
        seen.err         = error_code_i;
        seen.bval        = bool_value_i;
        seen.ival        = int_value_i;
        seen.sstart      = string_start_i;
        seen.slen        = string_length_i;
        seen.line        = token_line_i;
        seen.col         = token_col_i;
        seen.last_result = last_result_i;
        if (expected_tokens.size() == 0) begin
          log_failure("unexpected token", token_text(seen));
        end else begin
          want = expected_tokens.pop_front();
          if (seen !== want)
            log_failure("token mismatch",
                        {"expected ", token_text(want), " got ", token_text(seen)});
        end
      end
      if (in_valid_i && !in_stall_i) predict_tokens(in_byte_i, end_of_input_i);
      pending_o = expected_tokens.size();
    end
  end

endmodule

### sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] QUOTE     = 8'h22;
  localparam logic [7:0] BACKSLASH = 8'h5C;
  localparam string      PUNCT     = "()[]{},:";

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        end_of_input;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  token_kind;
  logic [2:0]  error_code;
  logic        bool_value;
  logic [62:0] int_value;
  logic [jtt_pkg::FieldWidth-1:0] string_start, string_length, token_line, token_col;
  logic        last_result;

  int unsigned fail_count, pending;
  int          items_sent    = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_cycles   = 0;

  byte unsigned blanks [4] = '{8'h20, 8'h09, 8'h0B, 8'h0A};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  json_text_tokenizer_unit DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .in_byte_i      (in_byte),
    .end_of_input_i (end_of_input),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .token_kind_o   (token_kind),
    .error_code_o   (error_code),
    .bool_value_o   (bool_value),
    .int_value_o    (int_value),
    .string_start_o (string_start),
    .string_length_o(string_length),
    .token_line_o   (token_line),
    .token_col_o    (token_col),
    .last_result_o  (last_result)
  );

  json_token_check token_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_byte_i      (in_byte),
    .end_of_input_i (end_of_input),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .token_kind_i   (token_kind),
    .error_code_i   (error_code),
    .bool_value_i   (bool_value),
    .int_value_i    (int_value),
    .string_start_i (string_start),
    .string_length_i(string_length),
    .token_line_i   (token_line),
    .token_col_i    (token_col),
    .last_result_i  (last_result),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  task automatic send_item(input logic [7:0] b, input logic eoi);
    int gap;
    gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(0, 15) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_byte      = b;
    end_of_input = eoi;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic finish_doc();
    send_item(8'($urandom), 1'b1);
  endtask

  function automatic logic [7:0] digit_char();
    return 8'(8'h30 + $urandom_range(0, 9));
  endfunction

  task automatic gen_blanks();
    repeat ($urandom_range(0, 2)) send_item(blanks[$urandom_range(0, 3)], 1'b0);
  endtask

  // broken: the token may end the document in an error or mid-token
  task automatic gen_number(output bit broken);
    int pick;
    pick   = $urandom_range(0, 9);
    broken = 1'b1;
    if (pick == 0) begin
      send_text("922337203685477580");
      send_item(digit_char(), 1'b0);
    end else if (pick == 1) begin
      repeat ($urandom_range(19, 21)) send_item(digit_char(), 1'b0);
    end else begin
      broken = 1'b0;
      repeat ($urandom_range(1, 6)) send_item(digit_char(), 1'b0);
    end
  endtask

  task automatic gen_string(output bit broken);
    logic [7:0] c;
    broken = 1'b0;
    send_item(QUOTE, 1'b0);
    repeat ($urandom_range(0, 8)) begin
      if ($urandom_range(0, 29) == 0) begin
        send_item(BACKSLASH, 1'b0);
        send_item(8'($urandom), 1'b0);
        broken = 1'b1;
      end else begin
        c = 8'($urandom);
        if (c == QUOTE || c == BACKSLASH) c = "a";
        send_item(c, 1'b0);
      end
    end
    if ($urandom_range(0, 19) == 0) broken = 1'b1;
    else send_item(QUOTE, 1'b0);
  endtask

  task automatic gen_keyword(output bit broken);
    string w;
    int    cut;
    case ($urandom_range(0, 2))
      0:       w = "null";
      1:       w = "true";
      default: w = "false";
    endcase
    broken = 1'b0;
    if ($urandom_range(0, 11) == 0) begin
      broken = 1'b1;
      cut    = $urandom_range(1, w.len() - 1);
      for (int i = 0; i < cut; i++) send_item(w[i], 1'b0);
      if ($urandom_range(0, 1)) send_item(8'($urandom_range(8'h61, 8'h7A)), 1'b0);
    end else begin
      send_text(w);
    end
  endtask

  task automatic gen_document();
    bit broken;
    int pick;
    broken = 1'b0;
    repeat ($urandom_range(1, 20)) begin
      if (!broken) begin
        gen_blanks();
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
          send_item(PUNCT[$urandom_range(0, 7)], 1'b0);
        end else if (pick < 50) begin
          gen_keyword(broken);
        end else if (pick < 70) begin
          gen_number(broken);
        end else if (pick < 95) begin
          gen_string(broken);
        end else begin
          send_item(8'($urandom), 1'b0);
          broken = 1'b1;
        end
      end
    end
    if (!broken) gen_blanks();
    finish_doc();
  endtask

  // receiver
  initial begin
    int gap, hold, transfers;
    out_stall = 1'b0;
    transfers = 0;
    @(posedge rst_n);
    forever begin
      if (hold_cycles > 0) begin
        hold        = hold_cycles;
        hold_cycles = 0;
        repeat (hold) begin
          @(negedge clk);
          out_stall = 1'b1;
        end
      end
      if (transfers % 40 == 0) recv_idle_pct = $urandom_range(0, 2) * 35;
      gap = ($urandom_range(0, 99) < recv_idle_pct) ? $urandom_range(0, 15) : 0;
      repeat (gap) begin
        @(negedge clk);
        out_stall = 1'b1;
      end
      @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      transfers++;
    end
  end

  initial begin
    int docs;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_byte      = '0;
    end_of_input = 1'b0;
    docs         = 0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // end inside a number, end inside a keyword, sticky bad byte,
    // end after an escaped quote, escape then closing quote, zero byte
    send_text("[7");
    finish_doc();
    send_text("tru");
    finish_doc();
    send_item(8'hFF, 1'b0);
    send_item("x", 1'b0);
    finish_doc();
    send_text("\"\\\"");
    finish_doc();
    send_text("\"\\n\"");
    finish_doc();
    send_item(8'h00, 1'b0);
    finish_doc();

    while (items_sent < 1300) begin
      docs++;
      if (docs % 30 == 5) begin
        hold_cycles   = 250;
        send_idle_pct = 0;
      end else if (docs % 4 == 0) begin
        send_idle_pct = $urandom_range(0, 2) * 35;
      end
      gen_document();
    end
    @(negedge clk);
    in_valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("tb NOT OK");
    $finish;
  end

endmodule

### files.f
src/jtt_pkg.sv
src/jtt_scan.sv
src/jtt_result_queue.sv
src/json_text_tokenizer_unit.sv
src/jtt_checker.sv
sim/json_token_check.sv
sim/tb.sv
